[hw/rtl/cooperative_tick_task_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tick task scheduler
// Concurrent check wrappers with a common clock and reset guard.
// ----------------------------------------------------------------------------
`ifndef COOPERATIVE_TICK_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define COOPERATIVE_TICK_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Check that a property holds on every clock edge outside reset.
`define CTTS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define CTTS_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hw/rtl/ctts_pkg.sv]
// ----------------------------------------------------------------------------
// ctts_pkg
// Shared types and constants for the tick task scheduler.
// ----------------------------------------------------------------------------
package ctts_pkg;

  localparam int MAX_TASKS_DEFAULT = 16;
  localparam int RESULT_LIMIT      = 16;
  localparam int RES_CNT_W         = $clog2(RESULT_LIMIT + 1);

  localparam int CODE_W    = 8;
  localparam int TIME_W    = 32;
  localparam int PENDING_W = 8;
  localparam int MODE_W    = 2;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 16;

  localparam logic [PENDING_W-1:0] PENDING_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 2'd0,
    MODE_TICK     = 2'd1,
    MODE_DISPATCH = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [TIME_W-1:0]    delay;
    logic [TIME_W-1:0]    period;
    logic [PENDING_W-1:0] pending;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic exec;
    logic fin;
  } ctts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  count_zero;
    logic  last_slot;
    logic  run;
    logic  held_valid;
    logic  out_free;
  } ctts_status_t;

endpackage

[hw/rtl/ctts_ram.sv]
// ----------------------------------------------------------------------------
// ctts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/ctts_ctrl.sv]
// ----------------------------------------------------------------------------
// ctts_ctrl
// Sequencer for add, tick, dispatch and clear transactions.
// ----------------------------------------------------------------------------
module ctts_ctrl
  import ctts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic [1:0]   s_mode,
  output logic         s_tready,
  output ctts_cmd_t    cmd,
  input  ctts_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EX   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  mode_t  in_mode;

  assign in_mode = mode_t'(s_mode);

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if ((in_mode inside {MODE_TICK, MODE_DISPATCH}) && !status.count_zero) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EX;
      end
      ST_EX: begin
        // hold while a buffered run result cannot leave
        if (!(status.run && status.held_valid && !status.out_free)) begin
          cmd.exec   = 1'b1;
          state_next = status.last_slot ? ST_FIN : ST_RD;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/ctts_dpath.sv]
// ----------------------------------------------------------------------------
// ctts_dpath
// Task table, walk pointers, run buffer and output register.
// ----------------------------------------------------------------------------
`include "cooperative_tick_task_scheduler_unit_defines.svh"

module ctts_dpath
  import ctts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [MODE_W-1:0]     s_tuser,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  ctts_cmd_t             cmd,
  output ctts_status_t          status
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0]     MAX_CNT   = CNT_W'(MAX_TASKS);
  localparam logic [RES_CNT_W-1:0] RES_LIMIT = RES_CNT_W'(RESULT_LIMIT);

  // latched command
  mode_t             mode_q;
  logic [CODE_W-1:0] code_q;
  logic [TIME_W-1:0] delay_q;
  logic [TIME_W-1:0] period_q;

  // table walk
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rptr;
  logic [CNT_W-1:0]     wptr;
  logic [CNT_W-1:0]     rptr_inc;
  logic [CNT_W-1:0]     wptr_next;
  logic [RES_CNT_W-1:0] run_n;

  // one run result held back until its last flag is known
  logic              held_valid;
  logic [CODE_W-1:0] held_code;
  logic              held_rem;

  // output register
  logic              out_valid;
  logic              out_ok;
  logic              out_run;
  logic [CODE_W-1:0] out_code;
  logic              out_rem;
  logic              out_last;

  slot_t            rd_slot;
  slot_t            tick_slot;
  slot_t            disp_slot;
  slot_t            wr_slot;
  logic [SLOT_W-1:0] rd_bits;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             run;
  logic             keep;
  logic             room;
  logic             out_free;
  logic             last_slot;

  assign rd_slot   = slot_t'(rd_bits);
  assign rptr_inc  = rptr + CNT_W'(1);
  assign last_slot = (rptr_inc == count);
  assign room      = (count < MAX_CNT);
  assign out_free  = !out_valid || m_tready;

  assign run  = (mode_q == MODE_DISPATCH) && (rd_slot.pending != '0) && (run_n < RES_LIMIT);
  assign keep = !(run && (rd_slot.period == '0));
  assign wptr_next = wptr + CNT_W'(keep);

  always_comb begin
    tick_slot = rd_slot;
    if (rd_slot.delay != '0) begin
      tick_slot.delay = rd_slot.delay - TIME_W'(1);
    end else begin
      tick_slot.delay = rd_slot.period;
      if (rd_slot.pending != PENDING_MAX) begin
        tick_slot.pending = rd_slot.pending + PENDING_W'(1);
      end
    end
  end

  always_comb begin
    disp_slot = rd_slot;
    if (run) begin
      disp_slot.pending = rd_slot.pending - PENDING_W'(1);
    end
  end

  // table write port: tick rewrites in place, dispatch compacts, add appends
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[IDX_W-1:0];
    wr_slot = disp_slot;
    if (cmd.exec && (mode_q == MODE_TICK)) begin
      wr_en   = 1'b1;
      wr_addr = rptr[IDX_W-1:0];
      wr_slot = tick_slot;
    end else if (cmd.exec && (mode_q == MODE_DISPATCH)) begin
      wr_en   = keep;
      wr_addr = wptr[IDX_W-1:0];
      wr_slot = disp_slot;
    end else if (cmd.fin && (mode_q == MODE_ADD) && room) begin
      wr_en   = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_slot = '{code: code_q, delay: delay_q, period: period_q, pending: '0};
    end
  end

  ctts_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (cmd.rd_en),
    .rd_addr (rptr[IDX_W-1:0]),
    .rd_data (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rptr       <= '0;
      wptr       <= '0;
      run_n      <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      if (cmd.accept) begin
        mode_q     <= mode_t'(s_tuser);
        code_q     <= s_tdata[CODE_W-1:0];
        delay_q    <= s_tdata[CODE_W +: TIME_W];
        period_q   <= s_tdata[CODE_W + TIME_W +: TIME_W];
        rptr       <= '0;
        wptr       <= '0;
        run_n      <= '0;
        held_valid <= 1'b0;
        if (mode_t'(s_tuser) == MODE_CLEAR) begin
          count <= '0;
        end
      end

      if (cmd.exec) begin
        rptr <= rptr_inc;
        if (mode_q == MODE_DISPATCH) begin
          wptr <= wptr_next;
          if (last_slot) begin
            count <= wptr_next;
          end
          if (run) begin
            // release the previous run, it is not the final one
            if (held_valid) begin
              out_valid <= 1'b1;
              out_ok    <= 1'b0;
              out_run   <= 1'b1;
              out_code  <= held_code;
              out_rem   <= held_rem;
              out_last  <= 1'b0;
            end
            held_valid <= 1'b1;
            held_code  <= rd_slot.code;
            held_rem   <= (rd_slot.period == '0);
            run_n      <= run_n + RES_CNT_W'(1);
          end
        end
      end

      if (cmd.fin) begin
        out_valid <= 1'b1;
        out_ok    <= 1'b0;
        out_run   <= 1'b0;
        out_code  <= '0;
        out_rem   <= 1'b0;
        out_last  <= 1'b1;
        if (mode_q == MODE_ADD) begin
          out_ok <= room;
          if (room) begin
            count <= count + CNT_W'(1);
          end
        end else if ((mode_q == MODE_DISPATCH) && held_valid) begin
          out_run  <= 1'b1;
          out_code <= held_code;
          out_rem  <= held_rem;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {(OUT_DATA_W - CODE_W - 3)'(0), out_rem, out_code, out_run, out_ok};

  assign status.count_zero = (count == '0);
  assign status.last_slot  = last_slot;
  assign status.run        = run;
  assign status.held_valid = held_valid;
  assign status.out_free   = out_free;

  `CTTS_ASSERT(a_count_bound, clk, rst, count <= MAX_CNT, "task count above table size")
  `CTTS_ASSERT(a_run_bound, clk, rst, run_n <= RES_LIMIT, "dispatch ran past result limit")
  `CTTS_ASSERT(a_ptr_order, clk, rst, wptr <= rptr, "compaction write pointer passed read pointer")
  `CTTS_NEVER(a_idle_fields, clk, rst, out_valid && !out_run && (out_code != '0 || out_rem), "non-run result carries run fields")

endmodule

[hw/rtl/cooperative_tick_task_scheduler_unit.sv]
// Add and clear pass from acceptance to the finish state, which loads the result
// register once it is free. Tick and dispatch walk the task table slot by slot (RAM
// read, then update and write back) and then finish the same way.
// One transaction at a time: the next is accepted once the result
// register has been loaded by the final result of the current one.
// Reset (rst, synchronous, active high) empties the table and drops any result.
// ----------------------------------------------------------------------------
// cooperative_tick_task_scheduler_unit
// Time-triggered task table with add, tick, dispatch and clear commands.
// ----------------------------------------------------------------------------
module cooperative_tick_task_scheduler_unit
  import ctts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // task_code[7:0], start_delay[39:8],
                                          // repeat_period[71:40]
  input  logic [MODE_W-1:0]     s_tuser,  // mode[1:0]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // add_ok[0], run_valid[1], run_code[9:2],
                                          // removed[10], zero[15:11]
  output logic                  m_tlast   // last
);

  // Control and data split: the controller sequences the table walk, the
  // datapath owns the table RAM, the walk pointers and the result register.
  ctts_cmd_t    cmd;
  ctts_status_t status;

  ctts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_mode   (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Dispatch compacts the table in the same pass: a removed one-shot task is
  // simply not written back, and later slots move up behind the write pointer.
  ctts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
